// ----- design/hsv2rgb_pkg.sv -----
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and hue decoding for the HSV to RGB converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam int CHAN_W           = 8;
    localparam int FRAC_W           = 5;
    localparam int HUE_SECTOR_CODES = 30;      // hue codes per 60 degree sector
    localparam int NUM_SECTORS      = 6;
    localparam int SAT_MAX          = 255;
    localparam int FRAC_SCALE       = 7650;    // SAT_MAX * HUE_SECTOR_CODES
    localparam int AMP_W            = 13;      // holds FRAC_SCALE
    localparam int NUM_P_W          = 16;      // v * (255 - s)
    localparam int NUM_QT_W         = 21;      // v * (7650 - s * frac)

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t             sector;
        logic [FRAC_W-1:0]   frac;
    } hue_split_t;

    // Split a hue code into sector (mod 6) and position inside the sector.
    // Codes above 179 wrap back into the low sectors.
    function automatic hue_split_t hue_split(input logic [CHAN_W-1:0] hue);
        logic [3:0]        idx;
        logic [CHAN_W-1:0] base;
        hue_split_t        res;
        idx = '0;
        for (int k = 1; k <= 8; k++) begin
            if (hue >= CHAN_W'(k * HUE_SECTOR_CODES)) begin
                idx = 4'(k);
            end
        end
        base = CHAN_W'(idx * HUE_SECTOR_CODES);
        res.frac = FRAC_W'(hue - base);
        if (idx >= 4'(NUM_SECTORS)) begin
            res.sector = sector_t'(3'(idx - 4'(NUM_SECTORS)));
        end else begin
            res.sector = sector_t'(3'(idx));
        end
        return res;
    endfunction

endpackage

// ----- design/hsv2rgb_div.sv -----
// ---------------------------------------------------------------------------
// hsv2rgb_div
// Two-stage truncating division by a constant: reciprocal multiply gives an
// estimate that is exact or one low, a back-multiply and compare fixes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv2rgb_div #(
    parameter int NUM_W   = 16,
    parameter int DIVISOR = 255,
    parameter int QUO_W   = 8
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    output logic [QUO_W-1:0] quo
);

    // floor(2^NUM_W / DIVISOR); estimate error stays below one
    localparam int unsigned RECIP   = (32'd1 << NUM_W) / DIVISOR;
    localparam int          RECIP_W = $clog2(RECIP + 1);
    localparam int          PROD_W  = NUM_W + RECIP_W;

    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  est_next;
    logic [QUO_W-1:0]  est_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  back;
    logic [NUM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo_next;
    logic [QUO_W-1:0]  quo_reg;

    assign prod     = PROD_W'(num) * PROD_W'(RECIP);
    assign est_next = prod[NUM_W +: QUO_W];

    assign back     = NUM_W'(est_reg) * NUM_W'(DIVISOR);
    assign rem      = num_reg - back;
    assign quo_next = (rem >= NUM_W'(DIVISOR)) ? est_reg + QUO_W'(1) : est_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            est_reg <= est_next;
            num_reg <= num;
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// ----- design/hsv_to_rgb_converter.sv -----
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter
// Path: hue split and amplitudes, numerators, division, then channel select into the output register.
// Throughput: one pixel per cycle; the whole pipeline holds while the output
// register is full and m_tready is low.
// Reset: aresetn clears all stage valid bits; payload is not reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] hue, [15:8] saturation, [23:16] brightness_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    localparam int STAGES = 5;

    logic              pipe_en;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;

    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] val;
    hue_split_t        split;

    // stage 1: sector, amplitudes of the helper levels
    sector_t           s1_sector_reg;
    logic [CHAN_W-1:0] s1_val_reg;
    logic [CHAN_W-1:0] s1_amp_p_reg;
    logic [AMP_W-1:0]  s1_amp_q_reg;
    logic [AMP_W-1:0]  s1_amp_t_reg;
    logic [CHAN_W-1:0] s1_amp_p_next;
    logic [AMP_W-1:0]  s1_amp_q_next;
    logic [AMP_W-1:0]  s1_amp_t_next;

    // stage 2: numerators
    sector_t             s2_sector_reg;
    logic [CHAN_W-1:0]   s2_val_reg;
    logic [NUM_P_W-1:0]  s2_num_p_reg;
    logic [NUM_QT_W-1:0] s2_num_q_reg;
    logic [NUM_QT_W-1:0] s2_num_t_reg;

    // stages 3 and 4: side data beside the dividers
    sector_t           s3_sector_reg;
    logic [CHAN_W-1:0] s3_val_reg;
    sector_t           s4_sector_reg;
    logic [CHAN_W-1:0] s4_val_reg;
    logic [CHAN_W-1:0] lvl_p;
    logic [CHAN_W-1:0] lvl_q;
    logic [CHAN_W-1:0] lvl_t;

    // stage 5: output register
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;

    assign pipe_en  = !vld_reg[STAGES-1] || m_tready;
    assign s_tready = pipe_en;

    assign hue   = s_tdata[7:0];
    assign sat   = s_tdata[15:8];
    assign val   = s_tdata[23:16];
    assign split = hue_split(hue);

    assign s1_amp_p_next = CHAN_W'(SAT_MAX) - sat;
    assign s1_amp_q_next = AMP_W'(FRAC_SCALE) - AMP_W'(sat) * AMP_W'(split.frac);
    assign s1_amp_t_next = AMP_W'(FRAC_SCALE)
                         - AMP_W'(sat) * AMP_W'(FRAC_W'(HUE_SECTOR_CODES) - split.frac);

    assign vld_next = {vld_reg[STAGES-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_sector_reg <= split.sector;
            s1_val_reg    <= val;
            s1_amp_p_reg  <= s1_amp_p_next;
            s1_amp_q_reg  <= s1_amp_q_next;
            s1_amp_t_reg  <= s1_amp_t_next;

            s2_sector_reg <= s1_sector_reg;
            s2_val_reg    <= s1_val_reg;
            s2_num_p_reg  <= NUM_P_W'(s1_val_reg) * NUM_P_W'(s1_amp_p_reg);
            s2_num_q_reg  <= NUM_QT_W'(s1_val_reg) * NUM_QT_W'(s1_amp_q_reg);
            s2_num_t_reg  <= NUM_QT_W'(s1_val_reg) * NUM_QT_W'(s1_amp_t_reg);

            s3_sector_reg <= s2_sector_reg;
            s3_val_reg    <= s2_val_reg;
            s4_sector_reg <= s3_sector_reg;
            s4_val_reg    <= s3_val_reg;

            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
        end
    end

    hsv2rgb_div #(
        .NUM_W   (NUM_P_W),
        .DIVISOR (SAT_MAX),
        .QUO_W   (CHAN_W)
    ) u_div_p (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (s2_num_p_reg),
        .quo  (lvl_p)
    );

    hsv2rgb_div #(
        .NUM_W   (NUM_QT_W),
        .DIVISOR (FRAC_SCALE),
        .QUO_W   (CHAN_W)
    ) u_div_q (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (s2_num_q_reg),
        .quo  (lvl_q)
    );

    hsv2rgb_div #(
        .NUM_W   (NUM_QT_W),
        .DIVISOR (FRAC_SCALE),
        .QUO_W   (CHAN_W)
    ) u_div_t (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (s2_num_t_reg),
        .quo  (lvl_t)
    );

    always_comb begin
        unique case (s4_sector_reg)
            SECTOR_0: begin
                red_next = s4_val_reg; green_next = lvl_t;      blue_next = lvl_p;
            end
            SECTOR_1: begin
                red_next = lvl_q;      green_next = s4_val_reg; blue_next = lvl_p;
            end
            SECTOR_2: begin
                red_next = lvl_p;      green_next = s4_val_reg; blue_next = lvl_t;
            end
            SECTOR_3: begin
                red_next = lvl_p;      green_next = lvl_q;      blue_next = s4_val_reg;
            end
            SECTOR_4: begin
                red_next = lvl_t;      green_next = lvl_p;      blue_next = s4_val_reg;
            end
            default: begin
                red_next = s4_val_reg; green_next = lvl_p;      blue_next = lvl_q;
            end
        endcase
    end

    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = {blue_reg, green_reg, red_reg};

endmodule

// ----- tb/sv/hsv_to_rgb_converter_tb.sv -----
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Self-checking bench for the HSV to RGB pixel converter. Directed corner
// pixels go first, then random pixels, with random gaps on both streams, a
// stretch without gaps and one long output stall. Every accepted pixel is
// converted in the bench with exact integer math, and the expected color is
// compared channel by channel against the next output transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb
    import hsv2rgb_pkg::*;
();

    localparam int IDLE_PCT      = 21;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RESET_CYCLES  = 9;

    typedef struct packed {
        logic [CHAN_W-1:0] brightness_value;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] hue;
    } hsv_pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_pixel_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // [7:0] hue, [15:8] saturation, [23:16] brightness_value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [7:0] red, [15:8] green, [23:16] blue

    hsv_pixel_t  hsv_queue[$];
    rgb_pixel_t  rgb_expected[$];
    int          error_count = 0;
    bit          gaps_on     = 1'b1;
    bit          hold_req    = 1'b0;
    bit          hold_taken  = 1'b0;
    int          hold_left   = 0;
    int          stall_count = 0;

    hsv_to_rgb_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Exact integer conversion, floor at every division.
    function automatic rgb_pixel_t convert_pixel(input hsv_pixel_t px);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned frac;
        int unsigned lvl_p;
        int unsigned lvl_q;
        int unsigned lvl_t;
        sector_t     sec;
        rgb_pixel_t  c;
        h     = 32'(px.hue);
        s     = 32'(px.saturation);
        v     = 32'(px.brightness_value);
        sec   = sector_t'(3'((h / 30) % 6));
        frac  = h % 30;
        lvl_p = (v * (255 - s)) / 255;
        lvl_q = (v * (7650 - s * frac)) / 7650;
        lvl_t = (v * (7650 - s * (30 - frac))) / 7650;
        unique case (sec)
            SECTOR_0: begin
                c.red = CHAN_W'(v);     c.green = CHAN_W'(lvl_t); c.blue = CHAN_W'(lvl_p);
            end
            SECTOR_1: begin
                c.red = CHAN_W'(lvl_q); c.green = CHAN_W'(v);     c.blue = CHAN_W'(lvl_p);
            end
            SECTOR_2: begin
                c.red = CHAN_W'(lvl_p); c.green = CHAN_W'(v);     c.blue = CHAN_W'(lvl_t);
            end
            SECTOR_3: begin
                c.red = CHAN_W'(lvl_p); c.green = CHAN_W'(lvl_q); c.blue = CHAN_W'(v);
            end
            SECTOR_4: begin
                c.red = CHAN_W'(lvl_t); c.green = CHAN_W'(lvl_p); c.blue = CHAN_W'(v);
            end
            default: begin
                c.red = CHAN_W'(v);     c.green = CHAN_W'(lvl_p); c.blue = CHAN_W'(lvl_q);
            end
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0d ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Levels lean toward the ends of the range, where the math saturates.
    function automatic logic [CHAN_W-1:0] pick_level();
        unique case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    task automatic add_pixel(input int h, input int s, input int v);
        hsv_pixel_t px;
        px.hue              = CHAN_W'(h);
        px.saturation       = CHAN_W'(s);
        px.brightness_value = CHAN_W'(v);
        hsv_queue.push_back(px);
    endtask

    task automatic add_random(input int count);
        for (int i = 0; i < count; i++) begin
            add_pixel(int'($urandom_range(255)), int'(pick_level()), int'(pick_level()));
        end
    endtask

    task automatic wait_drained();
        while (hsv_queue.size() != 0 || s_tvalid) @(negedge aclk);
        while (rgb_expected.size() != 0) @(negedge aclk);
    endtask

    // Input driver: a new pixel goes out once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                rgb_expected.push_back(convert_pixel(hsv_pixel_t'(s_tdata)));
            end
            if (hsv_queue.size() != 0 && !(gaps_on && $urandom_range(99) < IDLE_PCT)) begin
                s_tdata  <= hsv_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side backpressure, plus one long hold to fill the pipeline.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        rgb_pixel_t got;
        rgb_pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = rgb_pixel_t'(m_tdata);
            if (rgb_expected.size() == 0) begin
                report_mismatch("unexpected transaction, word", int'(m_tdata), 0);
            end else begin
                want = rgb_expected.pop_front();
                if (got.red !== want.red) begin
                    report_mismatch("red", int'(got.red), int'(want.red));
                end
                if (got.green !== want.green) begin
                    report_mismatch("green", int'(got.green), int'(want.green));
                end
                if (got.blue !== want.blue) begin
                    report_mismatch("blue", int'(got.blue), int'(want.blue));
                end
            end
        end
    end

    // Watchdog: cycles with work outstanding but no transaction on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            !(s_tvalid || hsv_queue.size() != 0 || rgb_expected.size() != 0)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("%0d ns: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // corners: zero/full levels, sector borders, wrapped codes
        add_pixel(0, 255, 255);
        add_pixel(0, 0, 255);
        add_pixel(0, 255, 0);
        add_pixel(29, 255, 255);
        add_pixel(30, 255, 255);
        add_pixel(59, 255, 200);
        add_pixel(60, 255, 255);
        add_pixel(90, 128, 255);
        add_pixel(120, 255, 255);
        add_pixel(150, 255, 255);
        add_pixel(179, 255, 255);
        add_pixel(180, 255, 255);
        add_pixel(209, 1, 254);
        add_pixel(210, 255, 255);
        add_pixel(239, 255, 255);
        add_pixel(240, 255, 255);
        add_pixel(255, 255, 255);
        add_pixel(255, 0, 0);
        add_pixel(15, 128, 128);
        add_pixel(100, 170, 85);
        add_pixel(45, 255, 1);
        add_pixel(170, 85, 170);
        wait_drained();

        add_random(200);
        wait_drained();

        gaps_on = 1'b0;
        add_random(150);
        wait_drained();

        // long output stall while the input keeps streaming
        hold_req = 1'b1;
        add_random(130);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
